// ----- sv/kesc_pkg.sv -----
// kesc_pkg: shared types, byte codes and keypad match functions
// for the keypad escape decoder; depends on nothing
package kesc_pkg;

  localparam logic [7:0] ESC_BYTE    = 8'h1B;
  localparam logic [7:0] INTER_LO    = 8'h20;
  localparam logic [7:0] INTER_HI    = 8'h2F;
  localparam logic [7:0] PARAM_LO    = 8'h30;
  localparam logic [7:0] PARAM_HI    = 8'h3F;
  localparam logic [7:0] FINAL_LO    = 8'h30;
  localparam logic [7:0] FINAL_LO_CS = 8'h40;
  localparam logic [7:0] FINAL_HI    = 8'h7E;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_LEAD  = 3'd1;
  localparam logic [2:0] PH_THIRD = 3'd2;
  localparam logic [2:0] PH_PARAM = 3'd3;
  localparam logic [2:0] PH_INTER = 3'd4;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_KEY   = 2'd1;
  localparam logic [1:0] KIND_ALARM = 2'd2;

  localparam logic [4:0] KEY_MAX = 5'd21;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] lead_byte;
    logic [7:0] next_byte;
    logic [1:0] seq_length;
  } state_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] char_value;
    logic [4:0] key_code;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] code;
  } key_match_t;

  localparam state_t STATE_IDLE = '{phase: PH_IDLE, lead_byte: 8'h00,
                                    next_byte: 8'h00, seq_length: 2'd0};

  function automatic logic in_range(input logic [7:0] b, input logic [7:0] lo,
                                    input logic [7:0] hi);
    return (b >= lo) && (b <= hi);
  endfunction

  function automatic key_match_t match_single(input logic [7:0] b);
    key_match_t m;
    m.hit  = 1'b1;
    m.code = 5'd0;
    case (b)
      8'h41:   m.code = 5'd0;
      8'h42:   m.code = 5'd1;
      8'h43:   m.code = 5'd2;
      8'h44:   m.code = 5'd3;
      8'h50:   m.code = 5'd4;
      8'h51:   m.code = 5'd5;
      8'h52:   m.code = 5'd6;
      default: m.hit  = 1'b0;
    endcase
    return m;
  endfunction

  function automatic key_match_t match_pair(input logic [7:0] lead,
                                            input logic [7:0] fin);
    key_match_t m;
    logic [7:0] d_a;
    logic [7:0] d_p;
    logic [7:0] d_up;
    d_a    = fin - 8'h41;
    d_p    = fin - 8'h70 + 8'd8;
    d_up   = fin - 8'h50 + 8'd4;
    m.hit  = 1'b0;
    m.code = 5'd0;
    if (lead == 8'h5B) begin
      if (in_range(fin, 8'h41, 8'h44)) begin
        m.hit  = 1'b1;
        m.code = d_a[4:0];
      end
    end else if (lead == 8'h4F || lead == 8'h3F) begin
      if (in_range(fin, 8'h70, 8'h79)) begin
        m.hit  = 1'b1;
        m.code = d_p[4:0];
      end else if (fin == 8'h6E) begin
        m.hit  = 1'b1;
        m.code = 5'd20;
      end else if (fin == 8'h4D) begin
        m.hit  = 1'b1;
        m.code = 5'd21;
      end else if (lead == 8'h4F) begin
        if (in_range(fin, 8'h50, 8'h53)) begin
          m.hit  = 1'b1;
          m.code = d_up[4:0];
        end else if (fin == 8'h6D) begin
          m.hit  = 1'b1;
          m.code = 5'd18;
        end else if (fin == 8'h6C) begin
          m.hit  = 1'b1;
          m.code = 5'd19;
        end
      end
    end
    return m;
  endfunction

endpackage

// ----- sv/keypad_escape_decoder.sv -----
// keypad_escape_decoder: top level with input register, decode step and result register
// depends on kesc_pkg and kesc_step
//
// usage
//   input channel: in_valid_i / in_ready_o carry one terminal byte per beat
//   output channel: out_valid_o / out_ready_i carry one result beat: a plain
//   character, a decoded keypad key code or an alarm for an illegal sequence
//   a byte that opens an escape sequence from idle or extends one gives no result beat
//   a result beat is offered once its byte has passed the input register and
//   the decode step into the result register
//   throughput: one byte per cycle while the receiver does not stall, set by the
//   combinational decode step between the input register and the result register
//   a stalled receiver holds the result register; the byte behind it waits in
//   the input register and in_ready_o drops only when both are full and the
//   receiver holds off
//   reset clears both valid flags and returns the decoder to idle with no
//   sequence open
module keypad_escape_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] result_kind_o,
  output logic [7:0] char_value_o,
  output logic [4:0] key_code_o
);
  import kesc_pkg::*;

  logic       s1_valid_q;
  logic       s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_go;
  logic       out_valid_q;
  logic       out_valid_d;
  result_t    out_q;
  state_t     state_q;
  state_t     state_d;
  logic       res_valid;
  result_t    res;

  assign s1_go      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  kesc_step u_step (
    .state_i     (state_q),
    .byte_i      (s1_byte_q),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) s1_valid_d = 1'b1;
    else if (s1_go) s1_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_go && res_valid) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= STATE_IDLE;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_go) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) s1_byte_q <= in_byte_i;
    if (s1_go && res_valid) out_q <= res;
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_q.result_kind;
  assign char_value_o  = out_q.char_value;
  assign key_code_o    = out_q.key_code;

  // result kinds keep their side fields clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.result_kind != KIND_CHAR |-> out_q.char_value == 8'h00)
    else $error("char_value set on a non-character beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.result_kind != KIND_KEY |-> out_q.key_code == 5'd0)
    else $error("key_code set on a non-key beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.result_kind != 2'd3) &&
                    (out_q.key_code <= KEY_MAX))
    else $error("result beat out of range");

  // a waiting byte is neither lost nor overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_go |=> s1_valid_q && $stable(s1_byte_q))
    else $error("held byte lost");

  // decoder state moves only when a byte is consumed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_go |=> $stable(state_q))
    else $error("state changed without a byte");

endmodule

// ----- sv/kesc_step.sv -----
// kesc_step: next-state and result logic for one byte of the escape decoder
// depends on kesc_pkg
module kesc_step (
  input  kesc_pkg::state_t  state_i,
  input  logic [7:0]        byte_i,
  output kesc_pkg::state_t  state_o,
  output logic              res_valid_o,
  output kesc_pkg::result_t res_o
);
  import kesc_pkg::*;

  state_t     tk;
  logic       do_take;
  logic       do_finish;
  logic [7:0] fin_lo;
  logic       is_inter;
  logic       is_param;
  logic       is_lead_sel;
  logic       lead_y;
  logic [7:0] end_lo;
  key_match_t km;

  assign is_inter    = in_range(byte_i, INTER_LO, INTER_HI);
  assign is_param    = in_range(byte_i, PARAM_LO, PARAM_HI);
  assign is_lead_sel = (byte_i == 8'h3B) || (byte_i == 8'h3F) || (byte_i == 8'h4F) ||
                       (byte_i == 8'h59) || (byte_i == 8'h5B);
  assign lead_y      = (state_i.lead_byte == 8'h59);
  assign end_lo      = (state_i.lead_byte == 8'h4F || state_i.lead_byte == 8'h5B) ?
                       FINAL_LO_CS : FINAL_LO;
  assign fin_lo      = (state_i.phase == PH_PARAM) ? FINAL_LO_CS :
                       (state_i.phase == PH_LEAD)  ? FINAL_LO : end_lo;

  // state after taking this byte into the sequence
  always_comb begin
    tk = state_i;
    if (state_i.seq_length == 2'd0) tk.lead_byte = byte_i;
    else if (state_i.seq_length == 2'd1) tk.next_byte = byte_i;
    if (state_i.seq_length != 2'd3) tk.seq_length = state_i.seq_length + 2'd1;
  end

  // table match on the completed sequence
  always_comb begin
    km = '{hit: 1'b0, code: 5'd0};
    if (in_range(byte_i, fin_lo, FINAL_HI)) begin
      if (tk.seq_length == 2'd1) km = match_single(tk.lead_byte);
      else if (tk.seq_length == 2'd2) km = match_pair(tk.lead_byte, tk.next_byte);
    end
  end

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '{result_kind: KIND_ALARM, char_value: 8'h00, key_code: 5'd0};
    do_take     = 1'b0;
    do_finish   = 1'b0;
    if (state_i.phase == PH_IDLE || state_i.phase > PH_INTER) begin
      state_o = STATE_IDLE;
      if (byte_i == ESC_BYTE) begin
        state_o.phase = PH_LEAD;
      end else begin
        res_valid_o       = 1'b1;
        res_o.result_kind = KIND_CHAR;
        res_o.char_value  = byte_i;
      end
    end else if (byte_i == ESC_BYTE) begin
      state_o       = STATE_IDLE;
      state_o.phase = PH_LEAD;
      res_valid_o   = 1'b1;
    end else begin
      case (state_i.phase)
        PH_LEAD: begin
          if (is_lead_sel) begin
            do_take       = 1'b1;
            state_o.phase = PH_THIRD;
          end else if (is_inter) begin
            do_take       = 1'b1;
            state_o.phase = PH_INTER;
          end else begin
            do_finish = 1'b1;
          end
        end
        PH_THIRD: begin
          if (state_i.lead_byte == 8'h5B && is_param) begin
            do_take       = 1'b1;
            state_o.phase = PH_PARAM;
          end else if (is_inter) begin
            do_take       = 1'b1;
            state_o.phase = PH_INTER;
          end else if (lead_y) begin
            state_o = STATE_IDLE;
          end else begin
            do_finish = 1'b1;
          end
        end
        PH_PARAM: begin
          if (is_param) begin
            do_take = 1'b1;
          end else if (is_inter) begin
            do_take       = 1'b1;
            state_o.phase = PH_INTER;
          end else begin
            do_finish = 1'b1;
          end
        end
        default: begin
          if (is_inter) begin
            do_take = 1'b1;
          end else if (lead_y) begin
            state_o = STATE_IDLE;
          end else begin
            do_finish = 1'b1;
          end
        end
      endcase
      if (do_take) begin
        state_o.lead_byte  = tk.lead_byte;
        state_o.next_byte  = tk.next_byte;
        state_o.seq_length = tk.seq_length;
      end
      if (do_finish) begin
        state_o     = STATE_IDLE;
        res_valid_o = 1'b1;
        if (km.hit) begin
          res_o.result_kind = KIND_KEY;
          res_o.key_code    = km.code;
        end
      end
    end
  end

endmodule
